>>> rtl/mlfq_pkg.sv
package mlfq_pkg;

   localparam int MaxJobs = 16;
   localparam int JobIdxW = $clog2(MaxJobs);
   localparam int JobCntW = $clog2(MaxJobs + 1);
   localparam int TimeW = 21;
   localparam int ValW = 16;
   localparam int Levels = 3;

   localparam logic [1:0] CsrQuantum0 = 2'd0;
   localparam logic [1:0] CsrQuantum1 = 2'd1;
   localparam logic [1:0] CsrQuantum2 = 2'd2;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_ADMIT_SCAN,
      ST_ADMIT_PUSH,
      ST_PICK,
      ST_RUN,
      ST_AFTER,
      ST_JUMP,
      ST_RESULT,
      ST_CLEAR
   } state_type;

   typedef enum logic [1:0] {
      ADM_PRE,
      ADM_POST
   } admit_phase_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_reset;
      logic scan_step;
      logic admit_push;
      logic pop;
      logic run;
      logic requeue;
      logic jump;
      logic complete;
      logic clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic best_found;
      logic any_queued;
      logic job_finished;
      logic all_done;
      logic table_full;
   } status_type;

endpackage

>>> rtl/mlfq_datapath.sv
module mlfq_datapath
   import mlfq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [ValW-1:0]       req_arrival_time,
   input  logic [ValW-1:0]       req_burst_length,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [ValW-1:0]       csr_write_data,
   output logic [4:0]            res_job_id,
   output logic [TimeW-1:0]      res_start_time,
   output logic [TimeW-1:0]      res_completion_time,
   output logic [TimeW-1:0]      res_turnaround_time,
   output logic [TimeW-1:0]      res_waiting_time,
   output logic [TimeW-1:0]      res_response_time,
   output logic                  res_last_result
);

   logic [ValW-1:0]  quantum_ff [Levels];
   logic [ValW-1:0]  arrival_mem [MaxJobs];
   logic [ValW-1:0]  burst_mem [MaxJobs];
   logic [ValW-1:0]  remaining_mem [MaxJobs];
   logic [TimeW-1:0] start_mem [MaxJobs];
   logic [MaxJobs-1:0] started_ff, admitted_ff;
   logic [JobIdxW-1:0] queue_mem [Levels][MaxJobs];
   logic [JobIdxW-1:0] head_ff [Levels];
   logic [JobCntW-1:0] count_ff [Levels];
   logic [TimeW-1:0] time_ff;
   logic [JobCntW-1:0] job_count_ff, completed_ff;

   // Scan over the job table, one entry per cycle.
   logic [JobCntW-1:0] scan_ff;
   logic               best_valid_ff, any_pending_ff;
   logic [JobIdxW-1:0] best_ff;
   logic [ValW-1:0]    best_arrival_ff, next_arrival_ff;

   // The job on the processor and its level.
   logic [JobIdxW-1:0] cur_job_ff;
   logic [1:0]         cur_level_ff;
   logic [ValW-1:0]    exec_ff;

   logic [JobIdxW-1:0] scan_idx;
   logic [ValW-1:0]    scan_arr;
   logic               scan_pend;
   logic [1:0]         pick_level;
   logic [ValW-1:0]    quantum;
   logic [1:0]         requeue_level;
   logic [TimeW-1:0]   turnaround;

   assign scan_idx  = scan_ff[JobIdxW-1:0];
   assign scan_arr  = arrival_mem[scan_idx];
   assign scan_pend = !admitted_ff[scan_idx];

   always_comb begin
      if (count_ff[0] != '0) pick_level = 2'd0;
      else if (count_ff[1] != '0) pick_level = 2'd1;
      else pick_level = 2'd2;
   end

   always_comb begin
      quantum = quantum_ff[pick_level];
      if (quantum == '0) quantum = ValW'(1);
   end

   assign requeue_level = (cur_level_ff == 2'd2) ? 2'd2 : cur_level_ff + 2'd1;

   assign status.scan_done    = (scan_ff == job_count_ff);
   assign status.best_found   = best_valid_ff;
   assign status.any_queued   = (count_ff[0] != '0) || (count_ff[1] != '0)
                                || (count_ff[2] != '0);
   assign status.job_finished = (remaining_mem[cur_job_ff] == '0);
   assign status.all_done     = (completed_ff == job_count_ff);
   assign status.table_full   = (job_count_ff == JobCntW'(MaxJobs));

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff[0] <= ValW'(4);
         quantum_ff[1] <= ValW'(8);
         quantum_ff[2] <= ValW'(12);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrQuantum0: quantum_ff[0] <= csr_write_data;
            CsrQuantum1: quantum_ff[1] <= csr_write_data;
            CsrQuantum2: quantum_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !status.table_full) begin
         arrival_mem[job_count_ff[JobIdxW-1:0]]   <= req_arrival_time;
         burst_mem[job_count_ff[JobIdxW-1:0]]     <= req_burst_length;
      end
      if (cmd.load && !status.table_full)
         remaining_mem[job_count_ff[JobIdxW-1:0]] <= req_burst_length;
      else if (cmd.run)
         remaining_mem[cur_job_ff] <= remaining_mem[cur_job_ff] - exec_ff;
      if (cmd.pop && !started_ff[queue_mem[pick_level][head_ff[pick_level]]])
         start_mem[queue_mem[pick_level][head_ff[pick_level]]] <= time_ff;
      if (cmd.admit_push)
         queue_mem[0][JobIdxW'(head_ff[0] + count_ff[0][JobIdxW-1:0])] <= best_ff;
      if (cmd.requeue)
         queue_mem[requeue_level][JobIdxW'(head_ff[requeue_level]
            + count_ff[requeue_level][JobIdxW-1:0])] <= cur_job_ff;
      if (cmd.pop) begin
         cur_job_ff   <= queue_mem[pick_level][head_ff[pick_level]];
         cur_level_ff <= pick_level;
         exec_ff      <= (quantum < remaining_mem[queue_mem[pick_level][head_ff[pick_level]]])
                         ? quantum : remaining_mem[queue_mem[pick_level][head_ff[pick_level]]];
      end
      if (cmd.scan_reset) begin
         best_valid_ff  <= 1'b0;
         any_pending_ff <= 1'b0;
      end else if (cmd.scan_step && !status.scan_done && scan_pend) begin
         if (!any_pending_ff || scan_arr < next_arrival_ff) next_arrival_ff <= scan_arr;
         any_pending_ff <= 1'b1;
         if ({5'd0, scan_arr} <= time_ff && (!best_valid_ff || scan_arr < best_arrival_ff)) begin
            best_valid_ff   <= 1'b1;
            best_ff         <= scan_idx;
            best_arrival_ff <= scan_arr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         started_ff   <= '0;
         admitted_ff  <= '0;
         time_ff      <= '0;
         job_count_ff <= '0;
         completed_ff <= '0;
         scan_ff      <= '0;
         for (int l = 0; l < Levels; l++) begin
            head_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
      end else begin
         if (cmd.load && !status.table_full) job_count_ff <= job_count_ff + 1'b1;
         if (cmd.scan_reset) scan_ff <= '0;
         else if (cmd.scan_step && !status.scan_done) scan_ff <= scan_ff + 1'b1;
         if (cmd.admit_push) begin
            admitted_ff[best_ff] <= 1'b1;
            count_ff[0] <= count_ff[0] + 1'b1;
         end
         if (cmd.pop) begin
            started_ff[queue_mem[pick_level][head_ff[pick_level]]] <= 1'b1;
            head_ff[pick_level]  <= head_ff[pick_level] + 1'b1;
            count_ff[pick_level] <= count_ff[pick_level] - 1'b1;
         end
         if (cmd.run) time_ff <= time_ff + TimeW'(exec_ff);
         if (cmd.requeue) count_ff[requeue_level] <= count_ff[requeue_level] + 1'b1;
         if (cmd.jump && any_pending_ff) time_ff <= TimeW'(next_arrival_ff);
         if (cmd.complete) completed_ff <= completed_ff + 1'b1;
      end
   end

   assign turnaround = time_ff - TimeW'(arrival_mem[cur_job_ff]);

   always_ff @(posedge clock) begin
      if (cmd.complete) begin
         res_job_id          <= 5'(cur_job_ff) + 5'd1;
         res_start_time      <= start_mem[cur_job_ff];
         res_completion_time <= time_ff;
         res_turnaround_time <= turnaround;
         res_waiting_time    <= turnaround - TimeW'(burst_mem[cur_job_ff]);
         res_response_time   <= start_mem[cur_job_ff] - TimeW'(arrival_mem[cur_job_ff]);
         res_last_result     <= (completed_ff + 1'b1) == job_count_ff;
      end
   end

endmodule

>>> rtl/mlfq_controller.sv
module mlfq_controller
   import mlfq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_last_job,
   output logic       rsp_valid,
   input  logic       rsp_ready
);

   state_type       state_ff, state_in;
   admit_phase_type phase_ff, phase_in;
   logic            rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         phase_ff     <= ADM_PRE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_job) begin
                  cmd.scan_reset = 1'b1;
                  phase_in = ADM_PRE;
                  state_in = ST_ADMIT_SCAN;
               end
            end
         end
         ST_ADMIT_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) state_in = ST_ADMIT_PUSH;
         end
         ST_ADMIT_PUSH: begin
            if (status.best_found) begin
               cmd.scan_reset = 1'b1;
               cmd.admit_push = 1'b1;
               state_in = ST_ADMIT_SCAN;
            end else if (phase_ff == ADM_PRE) state_in = ST_PICK;
            else state_in = ST_AFTER;
         end
         ST_PICK: begin
            if (status.all_done) state_in = ST_CLEAR;
            else if (status.any_queued) begin
               cmd.pop = 1'b1;
               state_in = ST_RUN;
            end else state_in = ST_JUMP;
         end
         ST_JUMP: begin
            // The scan that found nothing to admit also found the earliest
            // pending arrival, so time moves there.
            cmd.jump = 1'b1;
            cmd.scan_reset = 1'b1;
            phase_in = ADM_PRE;
            state_in = ST_ADMIT_SCAN;
         end
         ST_RUN: begin
            cmd.run = 1'b1;
            cmd.scan_reset = 1'b1;
            phase_in = ADM_POST;
            state_in = ST_ADMIT_SCAN;
         end
         ST_AFTER: begin
            if (status.job_finished) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  cmd.complete = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in = ST_RESULT;
               end
            end else begin
               cmd.requeue = 1'b1;
               cmd.scan_reset = 1'b1;
               phase_in = ADM_PRE;
               state_in = ST_ADMIT_SCAN;
            end
         end
         ST_RESULT: begin
            cmd.scan_reset = 1'b1;
            phase_in = ADM_PRE;
            state_in = ST_ADMIT_SCAN;
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

endmodule

>>> rtl/multilevel_feedback_queue_scheduler_unit.sv
// Three-level feedback queue scheduler. Jobs load at one per cycle; the job
// with req_last_job set starts the run, and one result per job comes out in
// order of completion, the final one with rsp_last_result high. Every
// admission pass scans the job table one entry per cycle; a pass runs
// before and after each slice, and once more for every job it admits. A
// result waiting on rsp_ready stalls the run at the next completion. The
// next set can load as soon as the run has finished, even while its last
// result still waits for its transfer.
module multilevel_feedback_queue_scheduler_unit
   import mlfq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [ValW-1:0]    req_arrival_time,
   input  logic [ValW-1:0]    req_burst_length,
   input  logic               req_last_job,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_job_id,
   output logic [TimeW-1:0]   rsp_start_time,
   output logic [TimeW-1:0]   rsp_completion_time,
   output logic [TimeW-1:0]   rsp_turnaround_time,
   output logic [TimeW-1:0]   rsp_waiting_time,
   output logic [TimeW-1:0]   rsp_response_time,
   output logic               rsp_last_result,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [ValW-1:0]    csr_write_data
);

   cmd_type    cmd;
   status_type status;

   mlfq_controller u_ctrl (
      .clock, .reset, .status, .cmd,
      .req_valid, .req_ready, .req_last_job, .rsp_valid, .rsp_ready
   );

   mlfq_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .req_arrival_time, .req_burst_length,
      .csr_write_enable, .csr_index, .csr_write_data,
      .res_job_id(rsp_job_id), .res_start_time(rsp_start_time),
      .res_completion_time(rsp_completion_time),
      .res_turnaround_time(rsp_turnaround_time),
      .res_waiting_time(rsp_waiting_time),
      .res_response_time(rsp_response_time),
      .res_last_result(rsp_last_result)
   );

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready || rsp_last_result) else $error("load during run");
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_job_id)) else $error("result changed");
   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.pop, cmd.run, cmd.complete, cmd.clear})) else $error("cmd clash");

endmodule

>>> test/testbench.sv
module testbench;
   import mlfq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [4:0]       id;
      logic [TimeW-1:0] start_t;
      logic [TimeW-1:0] finish_t;
      logic [TimeW-1:0] turnaround;
      logic [TimeW-1:0] waiting;
      logic [TimeW-1:0] response;
      logic             last;
   } job_report_type;

   // Keeps its own copy of the quanta and of the job set being loaded, and
   // replays the whole schedule when the final job of a set is transferred.
   class schedule_scoreboard;
      logic [ValW-1:0] quantum [Levels];
      int              arrivals[$];
      int              bursts[$];
      job_report_type  reports_due[$];
      int              errors;
      int              reports_seen;
      int              sets_run;

      function new();
         quantum[0] = ValW'(4);
         quantum[1] = ValW'(8);
         quantum[2] = ValW'(12);
      endfunction

      function void admit_due(int now, ref bit admitted[MaxJobs], ref int lvl0[$]);
         int best;
         forever begin
            best = -1;
            for (int i = 0; i < arrivals.size(); i++)
               if (!admitted[i] && arrivals[i] <= now &&
                   (best < 0 || arrivals[i] < arrivals[best]))
                  best = i;
            if (best < 0)
               return;
            admitted[best] = 1;
            lvl0.push_back(best);
         end
      endfunction

      function void replay_schedule();
         int             remain [MaxJobs];
         int             first_run [MaxJobs];
         bit             started [MaxJobs];
         bit             admitted [MaxJobs];
         int             level_q [Levels][$];
         int             n, now, done, lvl, job, slice, turn, next_t;
         job_report_type r;
         n = arrivals.size();
         now = 0;
         done = 0;
         foreach (started[i]) begin
            started[i] = 0;
            admitted[i] = 0;
         end
         for (int i = 0; i < n; i++)
            remain[i] = bursts[i];
         while (done < n) begin
            admit_due(now, admitted, level_q[0]);
            lvl = 0;
            while (lvl < Levels && level_q[lvl].size() == 0)
               lvl++;
            if (lvl == Levels) begin
               next_t = -1;
               for (int i = 0; i < n; i++)
                  if (!admitted[i] && (next_t < 0 || arrivals[i] < next_t))
                     next_t = arrivals[i];
               if (next_t >= 0)
                  now = next_t;
               continue;
            end
            job = level_q[lvl].pop_front();
            if (!started[job]) begin
               started[job] = 1;
               first_run[job] = now;
            end
            slice = (quantum[lvl] == 0) ? 1 : int'(quantum[lvl]);
            if (remain[job] < slice)
               slice = remain[job];
            now += slice;
            remain[job] -= slice;
            // Jobs that arrived during the slice go ahead of the preempted one.
            admit_due(now, admitted, level_q[0]);
            if (remain[job] > 0) begin
               level_q[(lvl < Levels - 1) ? lvl + 1 : Levels - 1].push_back(job);
            end else begin
               done++;
               turn = now - arrivals[job];
               r.id = 5'(job + 1);
               r.start_t = TimeW'(first_run[job]);
               r.finish_t = TimeW'(now);
               r.turnaround = TimeW'(turn);
               r.waiting = TimeW'(turn - bursts[job]);
               r.response = TimeW'(first_run[job] - arrivals[job]);
               r.last = (done == n);
               reports_due.push_back(r);
            end
         end
      endfunction

      function void note_job(logic [ValW-1:0] arrival, logic [ValW-1:0] burst, logic last);
         if (arrivals.size() < MaxJobs) begin
            arrivals.push_back(int'(arrival));
            bursts.push_back(int'(burst));
         end
         if (last) begin
            replay_schedule();
            arrivals.delete();
            bursts.delete();
            sets_run++;
         end
      endfunction

      function void compare(string field, longint want, longint got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_report(job_report_type got);
         job_report_type want;
         reports_seen++;
         if (reports_due.size() == 0) begin
            $error("unexpected result transfer for job %0d", got.id);
            errors++;
            return;
         end
         want = reports_due.pop_front();
         compare("job_id", want.id, got.id);
         compare("start_time", want.start_t, got.start_t);
         compare("completion_time", want.finish_t, got.finish_t);
         compare("turnaround_time", want.turnaround, got.turnaround);
         compare("waiting_time", want.waiting, got.waiting);
         compare("response_time", want.response, got.response);
         compare("last_result", want.last, got.last);
      endfunction
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   logic [ValW-1:0]  req_arrival_time = 0;
   logic [ValW-1:0]  req_burst_length = 0;
   logic             req_last_job = 0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   logic [4:0]       rsp_job_id;
   logic [TimeW-1:0] rsp_start_time;
   logic [TimeW-1:0] rsp_completion_time;
   logic [TimeW-1:0] rsp_turnaround_time;
   logic [TimeW-1:0] rsp_waiting_time;
   logic [TimeW-1:0] rsp_response_time;
   logic             rsp_last_result;
   logic             csr_write_enable = 0;
   logic [1:0]       csr_index = CsrQuantum0;
   logic [ValW-1:0]  csr_write_data = 0;

   schedule_scoreboard sb = new();
   int  send_idle = 35;
   int  recv_idle = 65;
   bit  hold_request = 0;
   int  hold_left = 0;
   int  jobs_sent = 0;

   multilevel_feedback_queue_scheduler_unit dut (.*);

   always #2 clock = ~clock;

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      job_report_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.id = rsp_job_id;
         got.start_t = rsp_start_time;
         got.finish_t = rsp_completion_time;
         got.turnaround = rsp_turnaround_time;
         got.waiting = rsp_waiting_time;
         got.response = rsp_response_time;
         got.last = rsp_last_result;
         sb.check_report(got);
      end
   end

   task automatic send_job(int arrival, int burst, bit last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_arrival_time <= ValW'(arrival);
      req_burst_length <= ValW'(burst);
      req_last_job <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_job(ValW'(arrival), ValW'(burst), last);
      jobs_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (sb.reports_due.size() != 0)
         @(negedge clock);
      // The block ends its run and clears its tables after the last completion.
      repeat (60) @(negedge clock);
   endtask

   task automatic set_quanta(int q0, int q1, int q2);
      wait_drained();
      csr_write_enable <= 1;
      csr_index <= CsrQuantum0;
      csr_write_data <= ValW'(q0);
      @(negedge clock);
      csr_index <= CsrQuantum1;
      csr_write_data <= ValW'(q1);
      @(negedge clock);
      csr_index <= CsrQuantum2;
      csr_write_data <= ValW'(q2);
      @(negedge clock);
      csr_write_enable <= 0;
      sb.quantum[0] = ValW'(q0);
      sb.quantum[1] = ValW'(q1);
      sb.quantum[2] = ValW'(q2);
   endtask

   task automatic send_random_set(int size_n);
      int arrival, burst;
      for (int k = 0; k < size_n; k++) begin
         arrival = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(40);
         burst = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(30);
         send_job(arrival, burst, k == size_n - 1);
      end
   endtask

   task automatic random_phase(int target);
      while (jobs_sent < target)
         send_random_set(($urandom_range(9) == 0) ? $urandom_range(16, 18)
                                                  : $urandom_range(1, 6));
   endtask

   initial begin
      #20000000;
      $display("** multilevel_feedback_queue_scheduler_unit: FAILED **");
      $finish;
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Reset quanta: a lone zero burst, arrival ties, admissions during
      // slices and an idle gap that makes time jump forward.
      send_job(0, 0, 1);
      send_job(3, 10, 0);
      send_job(0, 5, 0);
      send_job(3, 1, 0);
      send_job(10, 0, 0);
      send_job(1, 20, 1);
      send_job(100, 3, 0);
      send_job(5, 2, 1);

      set_quanta(65535, 65535, 65535);
      send_job(65535, 65535, 0);
      send_job(0, 65535, 0);
      send_job(65535, 0, 1);

      set_quanta(1, 1, 1);
      send_job(2, 3, 0);
      send_job(0, 4, 0);
      send_job(1, 0, 1);

      set_quanta(2, 5, 9);
      random_phase(60);

      set_quanta($urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32));
      send_idle = 65;
      recv_idle = 35;
      random_phase(85);
      wait_drained();
      random_phase(110);

      set_quanta(4, 8, 12);
      send_idle = 0;
      recv_idle = 0;
      hold_request = 1;
      // More jobs than the table holds; the surplus ones are dropped.
      send_random_set(18);
      random_phase(160);

      wait_drained();
      repeat (100) @(negedge clock);
      $display("Ran %0d job sets from %0d job transfers, checked %0d completion reports.",
               sb.sets_run, jobs_sent, sb.reports_seen);
      if (sb.errors == 0)
         $display("** multilevel_feedback_queue_scheduler_unit: PASSED **");
      else
         $display("** multilevel_feedback_queue_scheduler_unit: FAILED **");
      $finish;
   end
endmodule

>>> files.f
rtl/mlfq_pkg.sv
rtl/mlfq_datapath.sv
rtl/mlfq_controller.sv
rtl/multilevel_feedback_queue_scheduler_unit.sv
test/testbench.sv
